/* src/json_string_unescape_macros.svh */
// ----------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shared concurrent assertion forms for the unescape block.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// JSON string unescape package
// Types, codes, widths and character helpers shared by the unescape block.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam int LEN_BITS = 16;
    localparam int EST_W    = LEN_BITS + 1;
    localparam int CMP_W    = (EST_W > 16) ? EST_W : 16;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [15:0] SURR_LO    = 16'hD800;
    localparam logic [15:0] SURR_HI    = 16'hDFFF;
    localparam logic [15:0] CP_1B_END  = 16'h0080;
    localparam logic [15:0] CP_2B_END  = 16'h0800;
    localparam logic [7:0]  LEAD_2B    = 8'hC0;
    localparam logic [7:0]  LEAD_3B    = 8'hE0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;
    localparam logic [7:0]  REPL_B0    = 8'hEF;
    localparam logic [7:0]  REPL_B1    = 8'hBF;
    localparam logic [7:0]  REPL_B2    = 8'hBD;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_STR,
        PH_ESC,
        PH_HEX,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic [15:0] decoded_count;
    } result_t;

    typedef struct packed {
        logic [1:0]        n;
        result_t [2:0]     res;
    } bundle_t;

    // Returns the valid flag in bit 4 and the digit value in bits 3:0.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    // Returns the valid flag in bit 8 and the decoded byte in bits 7:0.
    function automatic logic [8:0] escape_value(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: r = {1'b1, c};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, CH_LF};
            8'h72:   r = {1'b1, CH_CR};
            8'h74:   r = {1'b1, CH_TAB};
            default: r = 9'h000;
        endcase
        return r;
    endfunction

    function automatic result_t byte_result(input logic [7:0] b);
        result_t r;
        r.kind          = KIND_BYTE;
        r.out_byte      = b;
        r.status        = ST_OK;
        r.decoded_count = 16'h0000;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/json_string_unescape.sv */
// ----------------------------------------------------------------------------
// JSON string unescape
// Streaming decoder for one JSON string token: skips leading blanks,
// decodes simple and \u escapes to UTF-8, and ends with a status result.
// ----------------------------------------------------------------------------
//   Channel   Handshake                  Payload
//   item      item_valid / item_stall    action, data_byte
//   result    result_valid / result_stall kind, out_byte, status, decoded_count, last
//   config    cfg_valid / cfg_ready      cfg_data (max_decoded_len)
//
// An item is decoded in the cycle it is accepted and its results appear in the
// next cycle; one item can be accepted every cycle while results do not stall.
// An item with more than one result stalls the item channel until its last
// result leaves, since the result register hands out one result per transfer.
// Reset clears the string state and sets max_decoded_len to 64.
// A stalled result holds; the item channel stalls only while results of
// the previous item remain beyond the one leaving this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    output logic              item_stall,
    input  wire logic [1:0]   action,
    input  wire logic [7:0]   data_byte,
    output logic              result_valid,
    input  wire logic         result_stall,
    output logic              kind,
    output logic [7:0]        out_byte,
    output logic [1:0]        status,
    output logic [15:0]       decoded_count,
    output logic              last,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    jsu_pkg::bundle_t   bundle;
    jsu_pkg::result_t   head;
    logic               can_load;
    logic               accept;

    assign cfg_ready  = 1'b1;
    assign item_stall = !can_load;
    assign accept     = item_valid && can_load;

    jsu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .action    (action),
        .data_byte (data_byte),
        .bundle    (bundle)
    );

    jsu_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept && bundle.n != 2'd0),
        .bundle       (bundle),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head),
        .last         (last)
    );

    assign kind          = head.kind;
    assign out_byte      = head.out_byte;
    assign status        = head.status;
    assign decoded_count = head.decoded_count;

endmodule

`default_nettype wire

/* src/jsu_decode.sv */
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the string state and the length limit, and turns one accepted item
// into a bundle of up to three results in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               accept,
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         data_byte,
    output jsu_pkg::bundle_t        bundle
);

    jsu_pkg::phase_t                phase_reg, phase_next;
    logic [1:0]                     hex_cnt_reg, hex_cnt_next;
    logic [11:0]                    cp_reg, cp_next;
    logic [jsu_pkg::EST_W-1:0]      est_reg, est_next;
    logic [jsu_pkg::LEN_BITS-1:0]   emit_reg, emit_next;
    logic [15:0]                    max_len_reg;

    logic [4:0]                     hex;
    logic [8:0]                     esc;
    logic [15:0]                    cp_full;
    logic [1:0]                     est_add;
    logic [jsu_pkg::EST_W:0]        est_sum;
    logic [jsu_pkg::LEN_BITS:0]     emit_sum;
    logic [jsu_pkg::CMP_W-1:0]      emit_wide;
    logic [15:0]                    count_sat;
    logic                           too_long;

    assign hex     = jsu_pkg::hex_value(data_byte);
    assign esc     = jsu_pkg::escape_value(data_byte);
    assign cp_full = {cp_reg, hex[3:0]};

    assign emit_wide = jsu_pkg::CMP_W'(emit_reg);
    assign count_sat = (emit_wide > jsu_pkg::CMP_W'(16'hFFFF)) ? 16'hFFFF : emit_wide[15:0];
    assign too_long  = jsu_pkg::CMP_W'(est_reg) > jsu_pkg::CMP_W'(max_len_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next     = cp_reg;
        est_add     = 2'd0;
        bundle.n    = 2'd0;
        bundle.res  = '0;

        case (action)
            jsu_pkg::ACT_START:
            begin
                phase_next   = jsu_pkg::PH_WAIT;
                hex_cnt_next = 2'd0;
                cp_next      = 12'h000;
            end
            jsu_pkg::ACT_END:
            begin
                if (phase_reg != jsu_pkg::PH_DONE)
                begin
                    phase_next           = jsu_pkg::PH_DONE;
                    bundle.n             = 2'd1;
                    bundle.res[0].kind   = jsu_pkg::KIND_STATUS;
                    bundle.res[0].status = jsu_pkg::ST_MALFORMED;
                end
            end
            jsu_pkg::ACT_DATA:
            begin
                case (phase_reg)
                    jsu_pkg::PH_WAIT:
                    begin
                        if (data_byte == jsu_pkg::CH_QUOTE)
                        begin
                            phase_next = jsu_pkg::PH_STR;
                        end
                        else if (!(data_byte inside {jsu_pkg::CH_SPACE, jsu_pkg::CH_TAB,
                                                     jsu_pkg::CH_CR, jsu_pkg::CH_LF}))
                        begin
                            phase_next           = jsu_pkg::PH_DONE;
                            bundle.n             = 2'd1;
                            bundle.res[0].kind   = jsu_pkg::KIND_STATUS;
                            bundle.res[0].status = jsu_pkg::ST_MALFORMED;
                        end
                    end
                    jsu_pkg::PH_STR:
                    begin
                        if (data_byte == jsu_pkg::CH_QUOTE)
                        begin
                            phase_next         = jsu_pkg::PH_DONE;
                            bundle.n           = 2'd1;
                            bundle.res[0].kind = jsu_pkg::KIND_STATUS;
                            if (too_long)
                            begin
                                bundle.res[0].status = jsu_pkg::ST_TOO_LONG;
                            end
                            else
                            begin
                                bundle.res[0].status        = jsu_pkg::ST_OK;
                                bundle.res[0].decoded_count = count_sat;
                            end
                        end
                        else if (data_byte == jsu_pkg::CH_BACKSLASH)
                        begin
                            phase_next = jsu_pkg::PH_ESC;
                        end
                        else if (data_byte < jsu_pkg::CH_SPACE)
                        begin
                            phase_next           = jsu_pkg::PH_DONE;
                            bundle.n             = 2'd1;
                            bundle.res[0].kind   = jsu_pkg::KIND_STATUS;
                            bundle.res[0].status = jsu_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            est_add       = 2'd1;
                            bundle.n      = 2'd1;
                            bundle.res[0] = jsu_pkg::byte_result(data_byte);
                        end
                    end
                    jsu_pkg::PH_ESC:
                    begin
                        if (data_byte == jsu_pkg::CH_U)
                        begin
                            phase_next   = jsu_pkg::PH_HEX;
                            hex_cnt_next = 2'd0;
                            cp_next      = 12'h000;
                        end
                        else if (!esc[8])
                        begin
                            phase_next           = jsu_pkg::PH_DONE;
                            bundle.n             = 2'd1;
                            bundle.res[0].kind   = jsu_pkg::KIND_STATUS;
                            bundle.res[0].status = jsu_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            phase_next    = jsu_pkg::PH_STR;
                            est_add       = 2'd1;
                            bundle.n      = 2'd1;
                            bundle.res[0] = jsu_pkg::byte_result(esc[7:0]);
                        end
                    end
                    jsu_pkg::PH_HEX:
                    begin
                        if (!hex[4])
                        begin
                            phase_next           = jsu_pkg::PH_DONE;
                            bundle.n             = 2'd1;
                            bundle.res[0].kind   = jsu_pkg::KIND_STATUS;
                            bundle.res[0].status = jsu_pkg::ST_MALFORMED;
                        end
                        else if (hex_cnt_reg != 2'd3)
                        begin
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                            cp_next      = {cp_reg[7:0], hex[3:0]};
                        end
                        else
                        begin
                            hex_cnt_next = 2'd0;
                            cp_next      = {cp_reg[7:0], hex[3:0]};
                            phase_next   = jsu_pkg::PH_STR;
                            est_add      = 2'd3;
                            if (cp_full < jsu_pkg::CP_1B_END)
                            begin
                                bundle.n      = 2'd1;
                                bundle.res[0] = jsu_pkg::byte_result(cp_full[7:0]);
                            end
                            else if (cp_full < jsu_pkg::CP_2B_END)
                            begin
                                bundle.n      = 2'd2;
                                bundle.res[0] = jsu_pkg::byte_result(
                                    jsu_pkg::LEAD_2B | {3'b000, cp_full[10:6]});
                                bundle.res[1] = jsu_pkg::byte_result(
                                    jsu_pkg::CONT_MARK | {2'b00, cp_full[5:0]});
                            end
                            else if (cp_full >= jsu_pkg::SURR_LO && cp_full <= jsu_pkg::SURR_HI)
                            begin
                                bundle.n      = 2'd3;
                                bundle.res[0] = jsu_pkg::byte_result(jsu_pkg::REPL_B0);
                                bundle.res[1] = jsu_pkg::byte_result(jsu_pkg::REPL_B1);
                                bundle.res[2] = jsu_pkg::byte_result(jsu_pkg::REPL_B2);
                            end
                            else
                            begin
                                bundle.n      = 2'd3;
                                bundle.res[0] = jsu_pkg::byte_result(
                                    jsu_pkg::LEAD_3B | {4'b0000, cp_full[15:12]});
                                bundle.res[1] = jsu_pkg::byte_result(
                                    jsu_pkg::CONT_MARK | {2'b00, cp_full[11:6]});
                                bundle.res[2] = jsu_pkg::byte_result(
                                    jsu_pkg::CONT_MARK | {2'b00, cp_full[5:0]});
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign est_sum  = {1'b0, est_reg} + (jsu_pkg::EST_W + 1)'(est_add);
    assign emit_sum = {1'b0, emit_reg}
                      + ((bundle.res[0].kind == jsu_pkg::KIND_BYTE)
                         ? (jsu_pkg::LEN_BITS + 1)'(bundle.n)
                         : (jsu_pkg::LEN_BITS + 1)'(0));

    always_comb
    begin
        if (action == jsu_pkg::ACT_START)
        begin
            est_next  = '0;
            emit_next = '0;
        end
        else
        begin
            est_next  = est_sum[jsu_pkg::EST_W] ? '1 : est_sum[jsu_pkg::EST_W-1:0];
            emit_next = emit_sum[jsu_pkg::LEN_BITS] ? '1 : emit_sum[jsu_pkg::LEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= jsu_pkg::PH_WAIT;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 12'h000;
            est_reg     <= '0;
            emit_reg    <= '0;
            max_len_reg <= 16'd64;
        end
        else
        begin
            if (cfg_write)
            begin
                max_len_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                hex_cnt_reg <= hex_cnt_next;
                cp_reg      <= cp_next;
                est_reg     <= est_next;
                emit_reg    <= emit_next;
            end
        end
    end

endmodule

`default_nettype wire

/* src/jsu_out.sv */
// ----------------------------------------------------------------------------
// JSON string unescape result queue
// Registers a bundle of up to three results, hands them out one per
// transfer, and loads the next when empty or as the last result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_macros.svh"

module jsu_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire jsu_pkg::bundle_t   bundle,
    output logic                    can_load,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output jsu_pkg::result_t        head,
    output logic                    last
);

    logic [1:0]               cnt_reg, cnt_next;
    jsu_pkg::result_t [2:0]   res_reg, res_next;
    logic                     fire;
    logic                     load_ok;
    logic                     run_mid;
    logic                     status_head;
    logic                     byte_head;
    logic                     byte_clean;

    assign result_valid = (cnt_reg != 2'd0);
    assign fire         = result_valid && !result_stall;
    assign can_load     = (cnt_reg == 2'd0) || (fire && cnt_reg == 2'd1);
    assign head         = res_reg[0];
    assign last         = (cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        res_next = res_reg;
        if (fire)
        begin
            cnt_next    = cnt_reg - 2'd1;
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
        end
        if (load)
        begin
            cnt_next = bundle.n;
            res_next = bundle.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign load_ok     = can_load && bundle.n != 2'd0;
    assign run_mid     = fire && cnt_reg > 2'd1 && !load;
    assign status_head = result_valid && head.kind == jsu_pkg::KIND_STATUS;
    assign byte_head   = result_valid && head.kind == jsu_pkg::KIND_BYTE;
    assign byte_clean  = head.status == jsu_pkg::ST_OK && head.decoded_count == 16'h0000;

    `JSU_ASSERT_NOW(a_load_when_free, clk, rst_n, load, load_ok, "load while busy")
    `JSU_ASSERT_NEXT(a_run_continues, clk, rst_n, run_mid, result_valid, "result run broken")
    `JSU_ASSERT_NOW(a_status_is_last, clk, rst_n, status_head, last, "status not last of run")
    `JSU_ASSERT_NOW(a_byte_fields_clear, clk, rst_n, byte_head, byte_clean, "stray status fields")

endmodule

`default_nettype wire

/* verif/json_string_unescape_tb.sv */
// ----------------------------------------------------------------------------
// JSON string unescape testbench
// Drives JSON string tokens one byte per transfer and checks every decoded
// byte and final status against a cycle-free decoder kept in the bench. A
// short table of hand-picked bytes comes first, then random tokens, mostly
// well formed, under several length limits and several idle and stall mixes.
// ----------------------------------------------------------------------------

module json_string_unescape_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    localparam logic [jsu_pkg::EST_W-1:0] EST_MAX = '1;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [15:0] count;
        logic        last;
    } decoded_rec_t;

    typedef struct {
        logic [1:0]   act;
        logic [7:0]   c;
        bit           typed;
        decoded_rec_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  action = jsu_pkg::ACT_START;
    logic [7:0]  data_byte = 8'h00;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] decoded_count;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    jsu_pkg::phase_t              dec_phase = jsu_pkg::PH_WAIT;
    logic [1:0]                   hex_seen = '0;
    logic [15:0]                  cp_acc = '0;
    logic [jsu_pkg::EST_W-1:0]    est_len = '0;
    logic [jsu_pkg::LEN_BITS-1:0] emit_len = '0;
    logic [15:0]                  len_limit = 16'd64;

    decoded_rec_t step_out[$];
    decoded_rec_t expected_results[$];

    int mismatch_count = 0;
    int items_counted = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    json_string_unescape DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .action        (action),
        .data_byte     (data_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .out_byte      (out_byte),
        .status        (status),
        .decoded_count (decoded_count),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == jsu_pkg::CH_SPACE || c == jsu_pkg::CH_TAB ||
               c == jsu_pkg::CH_CR || c == jsu_pkg::CH_LF;
    endfunction

    function automatic logic [8:0] escape_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: r = {1'b1, c};
            CH_LOWER_B: r = {1'b1, 8'h08};
            CH_LOWER_F: r = {1'b1, 8'h0C};
            CH_LOWER_N: r = {1'b1, jsu_pkg::CH_LF};
            CH_LOWER_R: r = {1'b1, jsu_pkg::CH_CR};
            CH_LOWER_T: r = {1'b1, jsu_pkg::CH_TAB};
            default:    r = 9'h000;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE)
            v = 8'h10 | (c - CH_ZERO);
        else if (c >= CH_LOWER_A && c < CH_LOWER_A + 8'd6)
            v = 8'h10 | (c - CH_LOWER_A + 8'd10);
        else if (c >= CH_UPPER_A && c < CH_UPPER_A + 8'd6)
            v = 8'h10 | (c - CH_UPPER_A + 8'd10);
        return v[4:0];
    endfunction

    function automatic stim_row_t plain_row(input logic [1:0] a, input logic [7:0] c);
        stim_row_t r;
        r.act   = a;
        r.c     = c;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic stim_row_t status_row(input logic [1:0] a, input logic [7:0] c,
                                             input logic [1:0] st, input logic [15:0] n);
        stim_row_t r;
        r       = plain_row(a, c);
        r.typed = 1'b1;
        r.want  = '{kind: jsu_pkg::KIND_STATUS, data: 8'h00, status: st, count: n,
                    last: 1'b1};
        return r;
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] c);
        stim_row_t r;
        r       = plain_row(jsu_pkg::ACT_DATA, c);
        r.typed = 1'b1;
        r.want  = '{kind: jsu_pkg::KIND_BYTE, data: c, status: jsu_pkg::ST_OK,
                    count: 16'h0000, last: 1'b1};
        return r;
    endfunction

    task automatic add_estimate(input int unsigned amount);
        logic [31:0] sum;
        sum     = est_len + amount;
        est_len = (sum > EST_MAX) ? EST_MAX : sum[jsu_pkg::EST_W-1:0];
    endtask

    task automatic emit_byte(input logic [7:0] b);
        step_out.push_back('{kind: jsu_pkg::KIND_BYTE, data: b, status: jsu_pkg::ST_OK,
                             count: 16'h0000, last: 1'b0});
        if (emit_len != '1)
            emit_len++;
    endtask

    task automatic emit_status(input logic [1:0] st);
        logic [15:0] n;
        n = (st == jsu_pkg::ST_OK) ? emit_len : 16'h0000;
        step_out.push_back('{kind: jsu_pkg::KIND_STATUS, data: 8'h00, status: st, count: n,
                             last: 1'b0});
        dec_phase = jsu_pkg::PH_DONE;
    endtask

    task automatic decode_step(input logic [1:0] act, input logic [7:0] c);
        logic [8:0]   esc;
        logic [4:0]   nib;
        decoded_rec_t tail;
        step_out.delete();
        case (act)
            jsu_pkg::ACT_START:
            begin
                dec_phase = jsu_pkg::PH_WAIT;
                hex_seen  = '0;
                cp_acc    = '0;
                est_len   = '0;
                emit_len  = '0;
            end
            jsu_pkg::ACT_END:
            begin
                if (dec_phase != jsu_pkg::PH_DONE)
                    emit_status(jsu_pkg::ST_MALFORMED);
            end
            jsu_pkg::ACT_DATA:
            begin
                case (dec_phase)
                    jsu_pkg::PH_WAIT:
                    begin
                        if (c == jsu_pkg::CH_QUOTE)
                            dec_phase = jsu_pkg::PH_STR;
                        else if (!is_blank(c))
                            emit_status(jsu_pkg::ST_MALFORMED);
                    end
                    jsu_pkg::PH_STR:
                    begin
                        if (c == jsu_pkg::CH_QUOTE)
                            emit_status((est_len > len_limit) ? jsu_pkg::ST_TOO_LONG
                                                              : jsu_pkg::ST_OK);
                        else if (c == jsu_pkg::CH_BACKSLASH)
                            dec_phase = jsu_pkg::PH_ESC;
                        else if (c < jsu_pkg::CH_SPACE)
                            emit_status(jsu_pkg::ST_MALFORMED);
                        else
                        begin
                            add_estimate(1);
                            emit_byte(c);
                        end
                    end
                    jsu_pkg::PH_ESC:
                    begin
                        esc = escape_map(c);
                        if (c == jsu_pkg::CH_U)
                        begin
                            dec_phase = jsu_pkg::PH_HEX;
                            hex_seen  = '0;
                            cp_acc    = '0;
                        end
                        else if (!esc[8])
                            emit_status(jsu_pkg::ST_MALFORMED);
                        else
                        begin
                            add_estimate(1);
                            emit_byte(esc[7:0]);
                            dec_phase = jsu_pkg::PH_STR;
                        end
                    end
                    jsu_pkg::PH_HEX:
                    begin
                        nib = hex_nibble(c);
                        if (!nib[4])
                            emit_status(jsu_pkg::ST_MALFORMED);
                        else
                        begin
                            cp_acc = {cp_acc[11:0], nib[3:0]};
                            if (hex_seen != 2'd3)
                                hex_seen++;
                            else
                            begin
                                hex_seen = '0;
                                add_estimate(3);
                                if (cp_acc < jsu_pkg::CP_1B_END)
                                    emit_byte(cp_acc[7:0]);
                                else if (cp_acc < jsu_pkg::CP_2B_END)
                                begin
                                    emit_byte(jsu_pkg::LEAD_2B | {3'b000, cp_acc[10:6]});
                                    emit_byte(jsu_pkg::CONT_MARK | {2'b00, cp_acc[5:0]});
                                end
                                else if (cp_acc >= jsu_pkg::SURR_LO &&
                                         cp_acc <= jsu_pkg::SURR_HI)
                                begin
                                    emit_byte(jsu_pkg::REPL_B0);
                                    emit_byte(jsu_pkg::REPL_B1);
                                    emit_byte(jsu_pkg::REPL_B2);
                                end
                                else
                                begin
                                    emit_byte(jsu_pkg::LEAD_3B | {4'b0000, cp_acc[15:12]});
                                    emit_byte(jsu_pkg::CONT_MARK | {2'b00, cp_acc[11:6]});
                                    emit_byte(jsu_pkg::CONT_MARK | {2'b00, cp_acc[5:0]});
                                end
                                dec_phase = jsu_pkg::PH_STR;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        if (step_out.size() != 0)
        begin
            tail      = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
        end
    endtask

    task automatic send_item(input stim_row_t r);
        bit ignored;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= r.act;
        data_byte  <= r.c;
        do
            @(posedge clk);
        while (item_stall);
        ignored = (r.act == ACT_UNUSED) ||
                  (dec_phase == jsu_pkg::PH_DONE && r.act != jsu_pkg::ACT_START);
        if (!ignored)
            items_counted++;
        decode_step(r.act, r.c);
        if (r.typed)
            expected_results.push_back(r.want);
        else
            foreach (step_out[i])
                expected_results.push_back(step_out[i]);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(plain_row(jsu_pkg::ACT_DATA, b));
    endtask

    task automatic send_random_string();
        logic [7:0]  b;
        logic [15:0] cp;
        logic [3:0]  nib;
        send_item(plain_row(jsu_pkg::ACT_START, 8'($urandom_range(255))));
        if ($urandom_range(9) == 0)
        begin
            do
                b = 8'($urandom_range(255));
            while (b == jsu_pkg::CH_QUOTE || is_blank(b));
            send_byte(b);
            return;
        end
        repeat ($urandom_range(2))
        begin
            case ($urandom_range(3))
                0:       send_byte(jsu_pkg::CH_SPACE);
                1:       send_byte(jsu_pkg::CH_TAB);
                2:       send_byte(jsu_pkg::CH_CR);
                default: send_byte(jsu_pkg::CH_LF);
            endcase
        end
        send_byte(jsu_pkg::CH_QUOTE);
        repeat ($urandom_range(4))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    do
                        b = 8'($urandom_range(8'h20, 8'hFF));
                    while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BACKSLASH);
                    send_byte(b);
                end
                6, 7:
                begin
                    send_byte(jsu_pkg::CH_BACKSLASH);
                    case ($urandom_range(7))
                        0:       send_byte(jsu_pkg::CH_QUOTE);
                        1:       send_byte(jsu_pkg::CH_BACKSLASH);
                        2:       send_byte(jsu_pkg::CH_SLASH);
                        3:       send_byte(CH_LOWER_B);
                        4:       send_byte(CH_LOWER_F);
                        5:       send_byte(CH_LOWER_N);
                        6:       send_byte(CH_LOWER_R);
                        default: send_byte(CH_LOWER_T);
                    endcase
                end
                default:
                begin
                    case ($urandom_range(4))
                        0: cp = 16'($urandom_range(16'h007F));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: cp = 16'($urandom_range(jsu_pkg::SURR_LO, jsu_pkg::SURR_HI));
                        3: cp = 16'($urandom_range(16'hFFFF));
                        default:
                        begin
                            case ($urandom_range(9))
                                0:       cp = 16'h0000;
                                1:       cp = 16'h007F;
                                2:       cp = 16'h0080;
                                3:       cp = 16'h07FF;
                                4:       cp = 16'h0800;
                                5:       cp = 16'hD7FF;
                                6:       cp = jsu_pkg::SURR_LO;
                                7:       cp = jsu_pkg::SURR_HI;
                                8:       cp = 16'hE000;
                                default: cp = 16'hFFFF;
                            endcase
                        end
                    endcase
                    send_byte(jsu_pkg::CH_BACKSLASH);
                    send_byte(jsu_pkg::CH_U);
                    for (int k = 3; k >= 0; k--)
                    begin
                        nib = cp[4*k +: 4];
                        if (nib < 4'd10)
                            send_byte(CH_ZERO + {4'h0, nib});
                        else if ($urandom_range(1) == 1)
                            send_byte(CH_UPPER_A + {4'h0, nib} - 8'd10);
                        else
                            send_byte(CH_LOWER_A + {4'h0, nib} - 8'd10);
                    end
                end
            endcase
        end
        case ($urandom_range(13))
            0:
                send_byte(8'($urandom_range(8'h1F)));
            1:
            begin
                send_byte(jsu_pkg::CH_BACKSLASH);
                do
                    b = 8'($urandom_range(255));
                while (escape_map(b) != 9'h000 || b == jsu_pkg::CH_U);
                send_byte(b);
            end
            2:
            begin
                send_byte(jsu_pkg::CH_BACKSLASH);
                send_byte(jsu_pkg::CH_U);
                repeat ($urandom_range(3))
                    send_byte(CH_ZERO + 8'($urandom_range(9)));
                do
                    b = 8'($urandom_range(255));
                while (hex_nibble(b) != 5'h00);
                send_byte(b);
            end
            3:
                send_item(plain_row(jsu_pkg::ACT_END, 8'($urandom_range(255))));
            4:
                send_item(plain_row(jsu_pkg::ACT_START, 8'($urandom_range(255))));
            5:
            begin
                send_item(plain_row(ACT_UNUSED, 8'($urandom_range(255))));
                send_byte(jsu_pkg::CH_QUOTE);
            end
            6:
            begin
                send_byte(jsu_pkg::CH_QUOTE);
                send_byte(8'($urandom_range(255)));
                send_item(plain_row(jsu_pkg::ACT_END, 8'($urandom_range(255))));
            end
            default:
                send_byte(jsu_pkg::CH_QUOTE);
        endcase
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall, input int budget);
        int start_count;
        idle_pct    = sender_idle;
        stall_pct   = receiver_stall;
        start_count = items_counted;
        while (items_counted - start_count < budget)
            send_random_string();
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_len_limit(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        len_limit = v;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen    <= hold_seq;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        decoded_rec_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("transfer with nothing expected, kind", 32'(kind), 32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", 32'(kind), 32'(want.kind));
                if (out_byte !== want.data)
                    report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (decoded_count !== want.count)
                    report_mismatch("decoded_count", 32'(decoded_count), 32'(want.count));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t directed_rows[$];
        directed_rows = {
            status_row(jsu_pkg::ACT_END, 8'hFF, jsu_pkg::ST_MALFORMED, 16'd0),
            plain_row(jsu_pkg::ACT_START, 8'h00),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_TAB),
            status_row(jsu_pkg::ACT_DATA, 8'h78, jsu_pkg::ST_MALFORMED, 16'd0),
            plain_row(jsu_pkg::ACT_START, 8'h00),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_SPACE),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_QUOTE),
            byte_row(8'hFF),
            byte_row(jsu_pkg::CH_SPACE),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_BACKSLASH),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_U),
            plain_row(jsu_pkg::ACT_DATA, 8'h44),
            plain_row(jsu_pkg::ACT_DATA, 8'h66),
            plain_row(jsu_pkg::ACT_DATA, 8'h46),
            plain_row(jsu_pkg::ACT_DATA, 8'h66),
            status_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_QUOTE, jsu_pkg::ST_OK, 16'd5),
            plain_row(ACT_UNUSED, jsu_pkg::CH_QUOTE),
            plain_row(jsu_pkg::ACT_END, 8'h00),
            plain_row(jsu_pkg::ACT_DATA, 8'h00),
            plain_row(jsu_pkg::ACT_START, 8'hFF),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_QUOTE),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_BACKSLASH),
            status_row(jsu_pkg::ACT_DATA, 8'h71, jsu_pkg::ST_MALFORMED, 16'd0),
            plain_row(jsu_pkg::ACT_START, 8'h00),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_QUOTE),
            status_row(jsu_pkg::ACT_DATA, 8'h1F, jsu_pkg::ST_MALFORMED, 16'd0),
            plain_row(jsu_pkg::ACT_START, 8'h00),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_QUOTE),
            byte_row(8'h42),
            plain_row(jsu_pkg::ACT_START, 8'h00),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_QUOTE),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_BACKSLASH),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_U),
            status_row(jsu_pkg::ACT_DATA, 8'h47, jsu_pkg::ST_MALFORMED, 16'd0),
            plain_row(jsu_pkg::ACT_START, 8'h00),
            plain_row(jsu_pkg::ACT_DATA, jsu_pkg::CH_QUOTE),
            status_row(jsu_pkg::ACT_END, 8'h00, jsu_pkg::ST_MALFORMED, 16'd0)
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        settle();
        run_phase(0, 0, 10);
        settle();
        write_len_limit(16'h0000);
        run_phase(84, 0, 10);
        settle();
        write_len_limit(16'hFFFF);
        run_phase(0, 84, 10);
        settle();
        write_len_limit(16'($urandom_range(1, 16)));
        run_phase(17, 17, 10);
        settle();
        write_len_limit(16'd6);
        hold_seq++;
        run_phase(0, 0, 10);
        settle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/jsu_pkg.sv
src/jsu_decode.sv
src/jsu_out.sv
src/json_string_unescape.sv
verif/json_string_unescape_tb.sv
